// ----- sv/wsr_pkg.sv -----
// Shared types, constants and helper functions for the whisker steering reflex.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package wsr_pkg;

  localparam int NUM_WHISKERS_DEF = 6;

  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int MAP_W   = 60;
  localparam int SUM_W   = 27;
  localparam int GAIN_W  = 13;
  localparam int PROD_W  = SUM_W + GAIN_W;
  localparam int DRV_W   = 22;
  localparam int WIDE_W  = 24;

  // Request codes carried by req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_GAIN       = 3'd1;
  localparam logic [2:0] REG_ACCEL_LOW  = 3'd2;
  localparam logic [2:0] REG_ACCEL_HIGH = 3'd3;
  localparam logic [2:0] REG_REVERSE    = 3'd4;
  localparam logic [2:0] REG_REFRACTORY = 3'd5;
  localparam logic [2:0] REG_PULSE      = 3'd6;
  localparam logic [2:0] REG_MAP        = 3'd7;

  localparam logic [15:0] RST_THRESHOLD  = 16'd19661;
  localparam logic [12:0] RST_GAIN       = 13'd2048;
  localparam logic [15:0] RST_ACCEL_LOW  = 16'hE000;
  localparam logic [15:0] RST_ACCEL_HIGH = 16'h2000;
  localparam logic [14:0] RST_REVERSE    = 15'd0;
  localparam logic [15:0] RST_REFRACTORY = 16'd0;
  localparam logic [15:0] RST_PULSE      = 16'd1;
  localparam logic [59:0] RST_MAP        = 60'd290766127260501249;

  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  typedef struct packed {
    logic [15:0] contact_threshold;
    logic [12:0] gain;
    logic [15:0] accel_low;
    logic [15:0] accel_high;
    logic [14:0] reverse_floor;
    logic [15:0] refractory_length;
    logic [15:0] pulse_length;
    logic [59:0] whisker_map;
  } cfg_t;

  // Q10.30 product rounded to nearest Q11.11.
  function automatic logic [DRV_W-1:0] round_drive(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + (PROD_W+1)'(1 << 18);
    return t[PROD_W:19];
  endfunction

  // Raise to lo first, then lower to hi, so hi wins when the bounds cross.
  function automatic logic [15:0] clamp_drive(input logic signed [WIDE_W-1:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic signed [WIDE_W-1:0] t;
    logic signed [WIDE_W-1:0] l;
    logic signed [WIDE_W-1:0] h;
    l = WIDE_W'($signed(lo));
    h = WIDE_W'($signed(hi));
    t = v;
    if (t < l) t = l;
    if (t > h) t = h;
    return t[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/wsr_regs.sv -----
// Configuration register file behind an APB-style port.
// Depends on wsr_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps
`default_nettype none
module wsr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wsr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [wsr_pkg::DATA_W-1:0] pwdata,
  output logic      [wsr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output wsr_pkg::cfg_t                   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contact_threshold <= wsr_pkg::RST_THRESHOLD;
      cfg.gain              <= wsr_pkg::RST_GAIN;
      cfg.accel_low         <= wsr_pkg::RST_ACCEL_LOW;
      cfg.accel_high        <= wsr_pkg::RST_ACCEL_HIGH;
      cfg.reverse_floor     <= wsr_pkg::RST_REVERSE;
      cfg.refractory_length <= wsr_pkg::RST_REFRACTORY;
      cfg.pulse_length      <= wsr_pkg::RST_PULSE;
      cfg.whisker_map       <= wsr_pkg::RST_MAP;
    end else if (wr) begin
      case (idx)
        wsr_pkg::REG_THRESHOLD:  cfg.contact_threshold <= pwdata[15:0];
        wsr_pkg::REG_GAIN:       cfg.gain              <= pwdata[12:0];
        wsr_pkg::REG_ACCEL_LOW:  cfg.accel_low         <= pwdata[15:0];
        wsr_pkg::REG_ACCEL_HIGH: cfg.accel_high        <= pwdata[15:0];
        wsr_pkg::REG_REVERSE:    cfg.reverse_floor     <= pwdata[14:0];
        wsr_pkg::REG_REFRACTORY: cfg.refractory_length <= pwdata[15:0];
        wsr_pkg::REG_PULSE:      cfg.pulse_length      <= pwdata[15:0];
        wsr_pkg::REG_MAP:        cfg.whisker_map       <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wsr_pkg::REG_THRESHOLD:  prdata = 64'(cfg.contact_threshold);
      wsr_pkg::REG_GAIN:       prdata = 64'(cfg.gain);
      wsr_pkg::REG_ACCEL_LOW:  prdata = 64'(cfg.accel_low);
      wsr_pkg::REG_ACCEL_HIGH: prdata = 64'(cfg.accel_high);
      wsr_pkg::REG_REVERSE:    prdata = 64'(cfg.reverse_floor);
      wsr_pkg::REG_REFRACTORY: prdata = 64'(cfg.refractory_length);
      wsr_pkg::REG_PULSE:      prdata = 64'(cfg.pulse_length);
      wsr_pkg::REG_MAP:        prdata = 64'(cfg.whisker_map);
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/wsr_mul.sv -----
// Shared 27 x 13 unsigned multiplier with a registered product.
// Depends on wsr_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none
module wsr_mul (
  input  wire logic                       clk,
  input  wire logic [wsr_pkg::SUM_W-1:0]  a,
  input  wire logic [wsr_pkg::GAIN_W-1:0] b,
  output logic      [wsr_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= wsr_pkg::PROD_W'(a) * wsr_pkg::PROD_W'(b);
  end

endmodule
`default_nettype wire

// ----- sv/wsr_seq.sv -----
// Sequencer: contact store, per-side accumulation through the shared multiplier,
// pulse and refractory counters, held drives and the output register.
// Depends on wsr_pkg; drives the operands of wsr_mul and reads its product.
`timescale 1ns / 1ps
`default_nettype none
module wsr_seq #(
  parameter int NUM_WHISKERS = wsr_pkg::NUM_WHISKERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wsr_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic [2:0]                 whisker_index,
  input  wire logic [15:0]                contact_value,
  output logic      [wsr_pkg::SUM_W-1:0]  mul_a,
  output logic      [wsr_pkg::GAIN_W-1:0] mul_b,
  input  wire logic [wsr_pkg::PROD_W-1:0] mul_p,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [15:0]                left_accel,
  output logic      [15:0]                right_accel,
  output logic      [15:0]                steer_accel,
  output logic                            wedge_reverse
);

  localparam int IDX_W = (NUM_WHISKERS > 1) ? $clog2(NUM_WHISKERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WHISKERS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_GL    = 3'd3;
  localparam logic [2:0] S_GR    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                 state;
  logic [IDX_W-1:0]           cnt;
  logic [15:0]                store [NUM_WHISKERS];
  logic                       d_valid;
  logic [1:0]                 d_side;
  logic                       d_over;
  logic [wsr_pkg::SUM_W-1:0]  lsum;
  logic [wsr_pkg::SUM_W-1:0]  rsum;
  logic                       hit_l;
  logic                       hit_r;
  logic [wsr_pkg::DRV_W-1:0]  al;
  logic [wsr_pkg::DRV_W-1:0]  ar;
  logic [15:0]                pulse_left;
  logic [15:0]                refractory_left;
  logic [15:0]                held_left;
  logic [15:0]                held_right;
  logic                       held_wedge;

  logic                       accept;
  logic [9:0]                 ent;
  logic [15:0]                cur_v;
  logic                       cur_over;
  logic [wsr_pkg::DRV_W-1:0]  rev;
  logic [wsr_pkg::DRV_W-1:0]  ml;
  logic [wsr_pkg::DRV_W-1:0]  mr;
  logic signed [wsr_pkg::WIDE_W-1:0] dl;
  logic signed [wsr_pkg::WIDE_W-1:0] dr;
  logic signed [wsr_pkg::WIDE_W-1:0] diff;
  logic [15:0]                pulse_start;
  logic                       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  assign ent      = cfg.whisker_map[10*cnt +: 10];
  assign cur_v    = store[cnt];
  assign cur_over = cur_v > cfg.contact_threshold;

  // Wedge back-out is the larger of the gain term and the reverse floor, negated.
  assign rev = wsr_pkg::DRV_W'(cfg.reverse_floor);
  assign ml  = (al > rev) ? al : rev;
  assign mr  = (ar > rev) ? ar : rev;
  assign dl  = (hit_l & hit_r) ? -$signed({2'b00, ml}) : $signed({2'b00, al});
  assign dr  = (hit_l & hit_r) ? -$signed({2'b00, mr}) : $signed({2'b00, ar});
  assign diff = wsr_pkg::WIDE_W'($signed(held_left)) - wsr_pkg::WIDE_W'($signed(held_right));
  assign pulse_start = (cfg.pulse_length != 16'd0) ? cfg.pulse_length - 16'd1 : 16'd0;

  always_comb begin
    case (state)
      S_MAC: begin
        mul_a = wsr_pkg::SUM_W'(cur_v);
        mul_b = wsr_pkg::GAIN_W'(ent[9:2]);
      end
      S_GL: begin
        mul_a = lsum;
        mul_b = cfg.gain;
      end
      S_GR: begin
        mul_a = rsum;
        mul_b = cfg.gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WHISKERS; i++) store[i] <= '0;
    end else if (accept && req_type == wsr_pkg::REQ_SAMPLE &&
                 (32'(whisker_index) < NUM_WHISKERS)) begin
      store[whisker_index[IDX_W-1:0]] <= contact_value;
    end
  end

  // Products come back in the cycle after issue, together with the delayed tags.
  always_ff @(posedge clk) begin
    if (d_valid && d_over) begin
      if (d_side == wsr_pkg::SIDE_LEFT)  lsum <= lsum + mul_p[wsr_pkg::SUM_W-1:0];
      if (d_side == wsr_pkg::SIDE_RIGHT) rsum <= rsum + mul_p[wsr_pkg::SUM_W-1:0];
    end
    if (accept && req_type == wsr_pkg::REQ_TICK) begin
      lsum <= '0;
      rsum <= '0;
    end
    d_side <= ent[1:0];
    d_over <= cur_over;
    if (state == S_GR)  al <= wsr_pkg::round_drive(mul_p);
    if (state == S_FIN) ar <= wsr_pkg::round_drive(mul_p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      d_valid         <= 1'b0;
      hit_l           <= 1'b0;
      hit_r           <= 1'b0;
      pulse_left      <= '0;
      refractory_left <= '0;
      held_left       <= '0;
      held_right      <= '0;
      held_wedge      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      d_valid <= (state == S_MAC);
      case (state)
        S_IDLE: begin
          if (accept && req_type == wsr_pkg::REQ_TICK) begin
            cnt   <= '0;
            hit_l <= 1'b0;
            hit_r <= 1'b0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (cur_over && ent[1:0] == wsr_pkg::SIDE_LEFT)  hit_l <= 1'b1;
          if (cur_over && ent[1:0] == wsr_pkg::SIDE_RIGHT) hit_r <= 1'b1;
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_DRAIN: state <= S_GL;
        S_GL:    state <= S_GR;
        S_GR:    state <= S_FIN;
        S_FIN:   state <= S_DONE;
        S_DONE: begin
          if (refractory_left != 16'd0) begin
            refractory_left <= refractory_left - 16'd1;
            state <= S_IDLE;
          end else if (pulse_left != 16'd0) begin
            pulse_left <= pulse_left - 16'd1;
            if (pulse_left == 16'd1) refractory_left <= cfg.refractory_length;
            state <= S_OUT;
          end else if (hit_l || hit_r) begin
            held_wedge <= hit_l & hit_r;
            held_left  <= wsr_pkg::clamp_drive(dl, cfg.accel_low, cfg.accel_high);
            held_right <= wsr_pkg::clamp_drive(dr, cfg.accel_low, cfg.accel_high);
            pulse_left <= pulse_start;
            if (pulse_start == 16'd0) refractory_left <= cfg.refractory_length;
            state <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      left_accel    <= held_left;
      right_accel   <= held_right;
      steer_accel   <= wsr_pkg::clamp_drive(diff, cfg.accel_low, cfg.accel_high);
      wedge_reverse <= held_wedge;
    end
  end

endmodule
`default_nettype wire

// ----- sv/whisker_steer_reflex_top.sv -----
// Top level of the whisker steering reflex: config registers, sequencer and
// the shared multiplier. Depends on wsr_pkg, wsr_regs, wsr_mul and wsr_seq.
//
//   channel   handshake                    payload
//   input     in_valid / in_stall          req_type, whisker_index, contact_value
//   output    out_valid / out_stall        left_accel, right_accel, steer_accel,
//                                          wedge_reverse
//   config    psel/penable/pwrite/pready   paddr (byte 8*i), pwdata, prdata
//
// A contact sample is taken without a stall and gives no word.
// A control tick holds in_stall high through one multiply per whisker on the shared
// multiplier, a drain step, two gain multiplies, a finishing step and the decision step,
// and through the output step as well when it gives a word.
// The output word sits in its own register; a tick waits in its last step only
// while an earlier word is still stalled there.
// Reset (synchronous, rst high) clears the contact store, counters and held drives.
`timescale 1ns / 1ps
`default_nettype none
module whisker_steer_reflex_top #(
  parameter int NUM_WHISKERS = wsr_pkg::NUM_WHISKERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wsr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [wsr_pkg::DATA_W-1:0] pwdata,
  output logic      [wsr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic [2:0]                 whisker_index,
  input  wire logic [15:0]                contact_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [15:0]                left_accel,
  output logic      [15:0]                right_accel,
  output logic      [15:0]                steer_accel,
  output logic                            wedge_reverse
);

  wsr_pkg::cfg_t                cfg;
  logic [wsr_pkg::SUM_W-1:0]    mul_a;
  logic [wsr_pkg::GAIN_W-1:0]   mul_b;
  logic [wsr_pkg::PROD_W-1:0]   mul_p;

  wsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  wsr_seq #(
    .NUM_WHISKERS (NUM_WHISKERS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .whisker_index (whisker_index),
    .contact_value (contact_value),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .mul_p         (mul_p),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_accel    (left_accel),
    .right_accel   (right_accel),
    .steer_accel   (steer_accel),
    .wedge_reverse (wedge_reverse)
  );

endmodule
`default_nettype wire

// ----- tb/whisker_steer_reflex_checker.sv -----
// Scoreboard for the whisker steering reflex: follows the config bus and both channels,
// predicts every drive word and compares it with what the block delivers.
// Depends on wsr_pkg for register indexes, reset values and request codes.
`timescale 1ns / 1ps

module whisker_steer_reflex_checker #(
  parameter int NUM_WHISKERS = wsr_pkg::NUM_WHISKERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [wsr_pkg::ADDR_W-1:0] paddr,
  input  logic [wsr_pkg::DATA_W-1:0] pwdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       req_type,
  input  logic [2:0]                 whisker_index,
  input  logic [15:0]                contact_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [15:0]                left_accel,
  input  logic [15:0]                right_accel,
  input  logic [15:0]                steer_accel,
  input  logic                       wedge_reverse,
  output int                         drives_pending,
  output int                         failures
);

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] steer;
    logic        wedge;
  } drive_word_t;

  // Register copy.
  logic        [15:0] threshold;
  logic        [12:0] gain;
  logic signed [15:0] accel_lo;
  logic signed [15:0] accel_hi;
  logic        [14:0] reverse_min;
  logic        [15:0] refractory_len;
  logic        [15:0] pulse_len;
  logic        [59:0] wmap;

  // Block state copy.
  logic        [15:0] contact [NUM_WHISKERS];
  logic        [15:0] pulse_cnt;
  logic        [15:0] silent_cnt;
  logic signed [15:0] held_left;
  logic signed [15:0] held_right;
  logic               held_wedge;

  drive_word_t pending_drives[$];

  function automatic longint clamp_accel(input longint v);
    if (v < longint'(accel_lo)) v = longint'(accel_lo);
    if (v > longint'(accel_hi)) v = longint'(accel_hi);
    return v;
  endfunction

  // Q10.30 gain times sum, rounded to Q11.11.
  function automatic longint gain_round(input longint unsigned side_sum);
    longint unsigned p;
    p = side_sum * 64'(gain);
    return longint'((p + 64'd262144) >> 19);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      wsr_pkg::REG_THRESHOLD:  threshold = d[15:0];
      wsr_pkg::REG_GAIN:       gain = d[12:0];
      wsr_pkg::REG_ACCEL_LOW:  accel_lo = d[15:0];
      wsr_pkg::REG_ACCEL_HIGH: accel_hi = d[15:0];
      wsr_pkg::REG_REVERSE:    reverse_min = d[14:0];
      wsr_pkg::REG_REFRACTORY: refractory_len = d[15:0];
      wsr_pkg::REG_PULSE:      pulse_len = d[15:0];
      wsr_pkg::REG_MAP:        wmap = d[59:0];
      default: ;
    endcase
  endtask

  task automatic predict_steer(input logic rt, input logic [2:0] idx, input logic [15:0] val);
    logic [9:0]      ent;
    longint unsigned w;
    longint unsigned v;
    longint unsigned lmax;
    longint unsigned rmax;
    longint unsigned lsum;
    longint unsigned rsum;
    longint          al;
    longint          ar;
    longint          rev;
    logic            hit_l;
    logic            hit_r;
    drive_word_t     word;
    if (rt == wsr_pkg::REQ_SAMPLE) begin
      if (int'(idx) < NUM_WHISKERS) contact[idx] = val;
      return;
    end
    lmax = 0;
    rmax = 0;
    lsum = 0;
    rsum = 0;
    for (int i = 0; i < NUM_WHISKERS; i++) begin
      ent = wmap[10*i +: 10];
      w = 64'(ent[9:2]);
      v = 64'(contact[i]);
      if (ent[1:0] == wsr_pkg::SIDE_LEFT) begin
        if (v > lmax) lmax = v;
        if (v > 64'(threshold)) lsum += v * w;
      end else if (ent[1:0] == wsr_pkg::SIDE_RIGHT) begin
        if (v > rmax) rmax = v;
        if (v > 64'(threshold)) rsum += v * w;
      end
    end
    // While refractory the tick only counts down, contacts or not.
    if (silent_cnt != 0) begin
      silent_cnt--;
      return;
    end
    if (pulse_cnt != 0) begin
      pulse_cnt--;
      if (pulse_cnt == 0) silent_cnt = refractory_len;
    end else if (lmax > 64'(threshold) || rmax > 64'(threshold)) begin
      hit_l = lmax > 64'(threshold);
      hit_r = rmax > 64'(threshold);
      al = gain_round(lsum);
      ar = gain_round(rsum);
      if (hit_l && hit_r) begin
        rev = longint'(reverse_min);
        al = -((al > rev) ? al : rev);
        ar = -((ar > rev) ? ar : rev);
        held_wedge = 1'b1;
      end else begin
        held_wedge = 1'b0;
      end
      held_left = 16'(clamp_accel(al));
      held_right = 16'(clamp_accel(ar));
      pulse_cnt = (pulse_len != 0) ? pulse_len - 16'd1 : 16'd0;
      if (pulse_cnt == 0) silent_cnt = refractory_len;
    end else begin
      return;
    end
    word.left = held_left;
    word.right = held_right;
    word.steer = 16'(clamp_accel(longint'(held_left) - longint'(held_right)));
    word.wedge = held_wedge;
    pending_drives.insert(pending_drives.size(), word);
  endtask

  task automatic check_drive();
    drive_word_t want;
    if (pending_drives.size() == 0) begin
      failures++;
      $error("drive word with none pending: left %0d right %0d steer %0d wedge %0b",
             $signed(left_accel), $signed(right_accel), $signed(steer_accel), wedge_reverse);
      return;
    end
    want = pending_drives.pop_front();
    if (left_accel !== want.left) begin
      failures++;
      $error("left_accel: expected %0d, got %0d", $signed(want.left), $signed(left_accel));
    end
    if (right_accel !== want.right) begin
      failures++;
      $error("right_accel: expected %0d, got %0d", $signed(want.right), $signed(right_accel));
    end
    if (steer_accel !== want.steer) begin
      failures++;
      $error("steer_accel: expected %0d, got %0d", $signed(want.steer), $signed(steer_accel));
    end
    if (wedge_reverse !== want.wedge) begin
      failures++;
      $error("wedge_reverse: expected %0b, got %0b", want.wedge, wedge_reverse);
    end
  endtask

  initial failures = 0;

  always @(posedge clk) begin
    if (rst) begin
      threshold = wsr_pkg::RST_THRESHOLD;
      gain = wsr_pkg::RST_GAIN;
      accel_lo = wsr_pkg::RST_ACCEL_LOW;
      accel_hi = wsr_pkg::RST_ACCEL_HIGH;
      reverse_min = wsr_pkg::RST_REVERSE;
      refractory_len = wsr_pkg::RST_REFRACTORY;
      pulse_len = wsr_pkg::RST_PULSE;
      wmap = wsr_pkg::RST_MAP;
      for (int i = 0; i < NUM_WHISKERS; i++) contact[i] = 16'd0;
      pulse_cnt = 16'd0;
      silent_cnt = 16'd0;
      held_left = 16'sd0;
      held_right = 16'sd0;
      held_wedge = 1'b0;
      pending_drives.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[5:3], pwdata);
      if (out_valid && !out_stall) check_drive();
      if (in_valid && !in_stall) predict_steer(req_type, whisker_index, contact_value);
    end
    drives_pending <= pending_drives.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the whisker steering reflex: clock, reset, config writes,
// contact/tick stimulus and output stalls. Depends on wsr_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int NW = wsr_pkg::NUM_WHISKERS_DEF;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [wsr_pkg::ADDR_W-1:0]   paddr = '0;
  logic [wsr_pkg::DATA_W-1:0]   pwdata = '0;
  logic [wsr_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         req_type = 1'b0;
  logic [2:0]                   whisker_index = 3'd0;
  logic [15:0]                  contact_value = 16'd0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [15:0]                  left_accel;
  logic [15:0]                  right_accel;
  logic [15:0]                  steer_accel;
  logic                         wedge_reverse;

  int                           drives_pending;
  int                           failures;

  // Stimulus view of the config, used only to aim contacts at sides and threshold.
  logic [15:0]                  thr_now = wsr_pkg::RST_THRESHOLD;
  logic [59:0]                  map_now = wsr_pkg::RST_MAP;
  int                           sent = 0;
  bit                           send_calm = 1'b0;
  bit                           take_calm = 1'b0;
  logic                         out_taken = 1'b0;
  int                           stall_left = 0;

  always #1 clk = ~clk;

  whisker_steer_reflex_top #(.NUM_WHISKERS(NW)) i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .whisker_index(whisker_index), .contact_value(contact_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_accel(left_accel), .right_accel(right_accel),
    .steer_accel(steer_accel), .wedge_reverse(wedge_reverse)
  );

  whisker_steer_reflex_checker #(.NUM_WHISKERS(NW)) i_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .whisker_index(whisker_index), .contact_value(contact_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_accel(left_accel), .right_accel(right_accel),
    .steer_accel(steer_accel), .wedge_reverse(wedge_reverse),
    .drives_pending(drives_pending), .failures(failures)
  );

  initial begin
    #1_000_000;
    $display("[whisker_steer_reflex_top] ERROR");
    $finish;
  end

  // Receiver: after each accepted word, hold stall for a random number of valid cycles.
  always @(posedge clk) out_taken <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (out_taken) stall_left = take_calm ? 0 : $urandom_range(0, 14);
    if (stall_left != 0 && out_valid) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic rt, input logic [2:0] idx, input logic [15:0] val);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    whisker_index <= idx;
    contact_value <= val;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic sample(input logic [2:0] idx, input logic [15:0] val);
    send_item(wsr_pkg::REQ_SAMPLE, idx, val);
  endtask

  task automatic tick();
    send_item(wsr_pkg::REQ_TICK, 3'($urandom), 16'($urandom));
  endtask

  // Drain all words, then give a tick that made no word time to finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drives_pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == wsr_pkg::REG_THRESHOLD) thr_now = value[15:0];
    if (idx == wsr_pkg::REG_MAP) map_now = value[59:0];
  endtask

  function automatic logic [63:0] pick_edge(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [63:0] mid);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return mid;
    endcase
  endfunction

  task automatic program_random();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [59:0] m;
    case ($urandom_range(0, 7))
      0: begin
        lo = 16'($urandom_range(0, 20000));
        hi = 16'(-$urandom_range(0, 20000));
      end
      1: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      default: begin
        lo = 16'(-$urandom_range(0, 20000));
        hi = 16'($urandom_range(0, 20000));
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      m = wsr_pkg::RST_MAP;
    end else begin
      for (int i = 0; i < 6; i++)
        m[10*i +: 10] = {8'(pick_edge(0, 255, $urandom)), 2'($urandom)};
    end
    write_reg(wsr_pkg::REG_THRESHOLD, pick_edge(0, 65535, $urandom_range(0, 50000)));
    write_reg(wsr_pkg::REG_GAIN, pick_edge(0, 8191, $urandom_range(0, 8191)));
    write_reg(wsr_pkg::REG_ACCEL_LOW, 64'(lo));
    write_reg(wsr_pkg::REG_ACCEL_HIGH, 64'(hi));
    write_reg(wsr_pkg::REG_REVERSE, pick_edge(0, 32767, $urandom_range(0, 32767)));
    write_reg(wsr_pkg::REG_REFRACTORY, pick_edge(0, 65535, $urandom_range(0, 4)));
    write_reg(wsr_pkg::REG_PULSE, pick_edge(0, 65535, $urandom_range(0, 4)));
    write_reg(wsr_pkg::REG_MAP, 64'(m));
  endtask

  function automatic logic [15:0] over_thr();
    if (thr_now == 16'hFFFF) return 16'($urandom);
    return 16'($urandom_range(int'(thr_now) + 1, 65535));
  endfunction

  function automatic logic [15:0] under_thr();
    return 16'($urandom_range(0, int'(thr_now)));
  endfunction

  initial begin : stimulus
    int          target;
    int          guard;
    logic [1:0]  pat;
    logic [1:0]  side;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset config: whiskers 0-2 left, 3-5 right, gain 8.0.
    tick();                             // nothing touched yet, quiet
    sample(3'd0, 16'hFFFF);
    tick();
    tick();
    sample(3'd4, 16'd40000);
    tick();                             // both sides: wedge
    sample(3'd0, 16'd0);
    tick();
    sample(3'd6, 16'hFFFF);             // index past the last whisker, ignored
    sample(3'd7, 16'hFFFF);
    sample(3'd4, wsr_pkg::RST_THRESHOLD);
    tick();                             // at threshold does not count
    sample(3'd4, wsr_pkg::RST_THRESHOLD + 16'd1);
    tick();

    // Crossed clamp, zero pulse, refractory, full reverse, side code 3 and no-side whiskers.
    settle();
    write_reg(wsr_pkg::REG_THRESHOLD, 64'd0);
    write_reg(wsr_pkg::REG_GAIN, 64'd8191);
    write_reg(wsr_pkg::REG_ACCEL_LOW, 64'h7FFF);
    write_reg(wsr_pkg::REG_ACCEL_HIGH, 64'h8000);
    write_reg(wsr_pkg::REG_REVERSE, 64'h7FFF);
    write_reg(wsr_pkg::REG_REFRACTORY, 64'd2);
    write_reg(wsr_pkg::REG_PULSE, 64'd0);
    write_reg(wsr_pkg::REG_MAP,
              64'({10'h005, 10'h3FC, 10'h202, 10'h3FF, 10'h002, 10'h3FD}));
    sample(3'd0, 16'd1);
    tick();
    tick();
    tick();
    sample(3'd3, 16'hFFFF);
    tick();
    sample(3'd2, 16'hFFFF);
    tick();
    tick();
    tick();

    // Random phases: mostly whole contact frames aimed at chosen sides, then ticks.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      program_random();
      target = sent + 200;
      while (sent < target) begin
        send_calm = ($urandom_range(0, 3) == 0);
        take_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0) begin
          pat = 2'($urandom_range(0, 3));
          for (int i = 0; i < NW; i++) begin
            side = map_now[10*i +: 2];
            if ((side == wsr_pkg::SIDE_LEFT && pat[0]) ||
                (side == wsr_pkg::SIDE_RIGHT && pat[1]))
              sample(3'(i), over_thr());
            else
              sample(3'(i), under_thr());
          end
          repeat ($urandom_range(1, 6)) tick();
        end else begin
          send_item(1'($urandom), 3'($urandom), 16'($urandom));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (drives_pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    if (failures == 0 && drives_pending == 0) begin
      $display("[whisker_steer_reflex_top] OK");
    end else begin
      $display("[whisker_steer_reflex_top] ERROR");
    end
    $finish;
  end

endmodule
